// File: rtl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg: shared types and constants for the square matrix power block
// Fixed-point formats, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package smp_pkg;

   localparam int WORD_W     = 32;   // Q16.16 word
   localparam int FRAC_W     = 16;   // fraction bits
   localparam int CSR_ADDR_W = 3;    // byte address of two 32-bit registers
   localparam int DIM_REG_W  = 4;
   localparam int EXP_REG_W  = 16;

   localparam logic [WORD_W-1:0] Q_ONE      = 32'h0001_0000;
   localparam logic [WORD_W-1:0] SAT_POS    = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] SAT_NEG    = 32'h8000_0000;
   localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

   // register index, taken from address bit 2
   localparam logic CSR_DIMENSION = 1'b0;
   localparam logic CSR_EXPONENT  = 1'b1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/square_matrix_power_top.sv
// ----------------------------------------------------------------------------
// square_matrix_power_top: square matrix raised to a power, signed Q16.16
// Loads a matrix row-major, multiplies the source into the running result
// once per exponent step on one shared multiply-accumulate unit, then sends
// the powered matrix row-major with a last mark and a sticky clip flag.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------------
//   req      | in        | req_valid/req_stall  | element_value
//   rsp      | out       | rsp_valid/rsp_stall  | result_value, last_element,
//            |           |                      | saturated
//   csr      | in/out    | APB write/read       | dimension (0x0), exponent (0x4)
//
// Load takes one word per cycle. After the last element the input stalls
// while the single 32x32 multiplier takes one term of one dot product per
// cycle and then drains its pipeline, once per exponent step. The result
// then leaves one word per cycle when rsp is not stalled, n*n words, and the
// input stays stalled. A stall on rsp holds the output word and the sequencer.
// Reset is synchronous; the matrix stores need no clearing pass.
// ----------------------------------------------------------------------------
module square_matrix_power_top #(
   parameter int MAX_DIM = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input words
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [smp_pkg::WORD_W-1:0]      req_element_value,
   // result words
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [smp_pkg::WORD_W-1:0]      rsp_result_value,
   output logic                                   rsp_last_element,
   output logic                                   rsp_saturated,
   // configuration
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [smp_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [smp_pkg::WORD_W-1:0]             csr_pwdata,
   output logic [smp_pkg::WORD_W-1:0]             csr_prdata,
   output logic                                   csr_pready
);

   localparam int CELLS  = MAX_DIM * MAX_DIM;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int W      = smp_pkg::WORD_W;
   localparam int PROD_W = 2 * W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_DIM + 1) + 1;
   localparam int SH_W   = ACC_W - smp_pkg::FRAC_W;

   // ---------------------------------------------------------------- registers
   smp_pkg::state_type state_ff, state_in;

   logic [smp_pkg::DIM_REG_W-1:0] dim_ff, dim_in;
   logic [smp_pkg::EXP_REG_W-1:0] exp_ff, exp_in;
   logic [CNT_W-1:0]              lc_ff, lc_in;       // elements loaded
   logic [DIM_W-1:0]              n_ff, n_in;         // dimension in use
   logic [DIM_W-1:0]              i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [smp_pkg::EXP_REG_W-1:0] step_ff, step_in;
   logic                          bank_ff, bank_in;   // bank holding running result
   logic                          ident_ff, ident_in; // running result is identity
   logic                          clip_ff, clip_in;
   logic [CNT_W-1:0]              ecnt_ff, ecnt_in;   // words sent
   logic [DIM_W-1:0]              er_ff, er_in, ec_ff, ec_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_diag_ff, rsp_diag_in;

   // matrix stores and their read registers
   logic [W-1:0] src_ff   [CELLS];
   logic [W-1:0] run_a_ff [CELLS];
   logic [W-1:0] run_b_ff [CELLS];
   logic [W-1:0] src_rd_ff, run_a_rd_ff, run_b_rd_ff;

   // multiply-accumulate pipeline
   logic                     s1_valid_ff, s1_first_ff, s1_last_ff, s1_diag_ff;
   logic [ADDR_W-1:0]        s1_dst_ff;
   logic                     s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [ADDR_W-1:0]        s2_dst_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     s3_valid_ff;
   logic [ADDR_W-1:0]        s3_dst_ff;

   // ---------------------------------------------------------------- logic
   logic [DIM_W-1:0]         n_cur, nm1;
   logic [CNT_W-1:0]         total_cur, total_run, lc_next;
   logic [CNT_W-1:0]         src_addr, run_addr_mac, dst_addr;
   logic [ADDR_W-1:0]        run_addr;
   logic                     req_accept, rsp_adv, emit_rd, rd_en, pipe_empty, csr_write;
   logic signed [W-1:0]      op_a, op_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  prod_ext, acc_in, rounded;
   logic [SH_W-1:0]          shifted;
   logic [SH_W-W:0]          upper;
   logic                     wb_ovf;
   logic [W-1:0]             wb_value;

   // clamp the configured dimension into 1..MAX_DIM
   always_comb begin
      if (dim_ff == '0) begin
         n_cur = DIM_W'(1);
      end else if (int'(dim_ff) > MAX_DIM) begin
         n_cur = DIM_W'(MAX_DIM);
      end else begin
         n_cur = DIM_W'(dim_ff);
      end
   end

   assign total_cur  = CNT_W'(n_cur) * CNT_W'(n_cur);
   assign total_run  = CNT_W'(n_ff) * CNT_W'(n_ff);
   assign nm1        = n_ff - DIM_W'(1);
   assign req_stall  = (state_ff != smp_pkg::ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign rsp_adv    = !rsp_valid_ff || !rsp_stall;
   assign pipe_empty = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff;
   assign lc_next    = lc_ff + ((lc_ff < CNT_W'(CELLS)) ? CNT_W'(1) : CNT_W'(0));

   // flat row-major addresses: S[i][k], R[k][j], P[i][j]
   assign src_addr     = CNT_W'(i_ff) * CNT_W'(n_ff) + CNT_W'(k_ff);
   assign run_addr_mac = CNT_W'(k_ff) * CNT_W'(n_ff) + CNT_W'(j_ff);
   assign dst_addr     = CNT_W'(i_ff) * CNT_W'(n_ff) + CNT_W'(j_ff);
   assign run_addr     = (state_ff == smp_pkg::ST_EMIT) ? ecnt_ff[ADDR_W-1:0]
                                                         : run_addr_mac[ADDR_W-1:0];
   assign rd_en        = (state_ff == smp_pkg::ST_ISSUE) || emit_rd;

   // sequencer: load, issue dot-product terms, drain, send
   always_comb begin
      state_in     = state_ff;
      lc_in        = lc_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      step_in      = step_ff;
      bank_in      = bank_ff;
      ident_in     = ident_ff;
      clip_in      = clip_ff;
      ecnt_in      = ecnt_ff;
      er_in        = er_ff;
      ec_in        = ec_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_diag_in  = rsp_diag_ff;
      emit_rd      = 1'b0;

      unique case (state_ff)
         smp_pkg::ST_LOAD: begin
            if (req_accept) begin
               if (lc_next >= total_cur) begin
                  // matrix complete: start from the identity
                  lc_in    = '0;
                  n_in     = n_cur;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
                  step_in  = '0;
                  bank_in  = 1'b0;
                  ident_in = 1'b1;
                  clip_in  = 1'b0;
                  ecnt_in  = '0;
                  er_in    = '0;
                  ec_in    = '0;
                  state_in = (exp_ff == '0) ? smp_pkg::ST_EMIT : smp_pkg::ST_ISSUE;
               end else begin
                  lc_in = lc_next;
               end
            end
         end
         smp_pkg::ST_ISSUE: begin
            if (k_ff == nm1) begin
               k_in = '0;
               if (j_ff == nm1) begin
                  j_in = '0;
                  if (i_ff == nm1) begin
                     i_in     = '0;
                     state_in = smp_pkg::ST_DRAIN;
                  end else begin
                     i_in = i_ff + DIM_W'(1);
                  end
               end else begin
                  j_in = j_ff + DIM_W'(1);
               end
            end else begin
               k_in = k_ff + DIM_W'(1);
            end
         end
         smp_pkg::ST_DRAIN: begin
            // swap banks once the last product is written
            if (pipe_empty) begin
               step_in  = step_ff + smp_pkg::EXP_REG_W'(1);
               bank_in  = !bank_ff;
               ident_in = 1'b0;
               if (step_ff + smp_pkg::EXP_REG_W'(1) == exp_ff) begin
                  ecnt_in  = '0;
                  er_in    = '0;
                  ec_in    = '0;
                  state_in = smp_pkg::ST_EMIT;
               end else begin
                  state_in = smp_pkg::ST_ISSUE;
               end
            end
         end
         smp_pkg::ST_EMIT: begin
            if (rsp_adv) begin
               if (ecnt_ff < total_run) begin
                  emit_rd      = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = (ecnt_ff == total_run - CNT_W'(1));
                  rsp_diag_in  = (er_ff == ec_ff);
                  ecnt_in      = ecnt_ff + CNT_W'(1);
                  if (ec_ff == nm1) begin
                     ec_in = '0;
                     er_in = er_ff + DIM_W'(1);
                  end else begin
                     ec_in = ec_ff + DIM_W'(1);
                  end
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = smp_pkg::ST_LOAD;
               end
            end
         end
      endcase

      if (s3_valid_ff && wb_ovf) begin
         clip_in = 1'b1;
      end
   end

   // configuration port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      dim_in = dim_ff;
      exp_in = exp_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            smp_pkg::CSR_DIMENSION: dim_in = csr_pwdata[smp_pkg::DIM_REG_W-1:0];
            smp_pkg::CSR_EXPONENT:  exp_in = csr_pwdata[smp_pkg::EXP_REG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         smp_pkg::CSR_DIMENSION: csr_prdata = W'(dim_ff);
         smp_pkg::CSR_EXPONENT:  csr_prdata = W'(exp_ff);
      endcase
   end

   // multiply stage: the right operand is the identity on the first step
   assign op_a    = src_rd_ff;
   assign op_b    = ident_ff ? (s1_diag_ff ? smp_pkg::Q_ONE : W'(0))
                             : (bank_ff ? run_b_rd_ff : run_a_rd_ff);
   assign prod_in = op_a * op_b;

   // accumulate stage, full precision
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_in   = s2_first_ff ? prod_ext : acc_ff + prod_ext;

   // round to nearest, drop the fraction, saturate
   assign rounded  = acc_ff + ACC_W'(smp_pkg::ROUND_HALF);
   assign shifted  = rounded[ACC_W-1:smp_pkg::FRAC_W];
   assign upper    = shifted[SH_W-1:W-1];
   assign wb_ovf   = !((upper == '0) || (upper == '1));
   assign wb_value = !wb_ovf ? shifted[W-1:0]
                             : (shifted[SH_W-1] ? smp_pkg::SAT_NEG : smp_pkg::SAT_POS);

   // ---------------------------------------------------------------- clocked
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smp_pkg::ST_LOAD;
         dim_ff       <= smp_pkg::DIM_REG_W'(1);
         exp_ff       <= smp_pkg::EXP_REG_W'(1);
         lc_ff        <= '0;
         step_ff      <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dim_ff       <= dim_in;
         exp_ff       <= exp_in;
         lc_ff        <= lc_in;
         step_ff      <= step_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= (state_ff == smp_pkg::ST_ISSUE);
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      bank_ff     <= bank_in;
      ident_ff    <= ident_in;
      ecnt_ff     <= ecnt_in;
      er_ff       <= er_in;
      ec_ff       <= ec_in;
      rsp_last_ff <= rsp_last_in;
      rsp_diag_ff <= rsp_diag_in;
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      s1_first_ff <= (k_ff == '0);
      s1_last_ff  <= (k_ff == nm1);
      s1_diag_ff  <= (k_ff == j_ff);
      s1_dst_ff   <= dst_addr[ADDR_W-1:0];
      prod_ff     <= prod_in;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_dst_ff   <= s1_dst_ff;
      s3_dst_ff   <= s2_dst_ff;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // matrix stores: one write and one registered read each
   always_ff @(posedge clock) begin
      if (req_accept && (lc_ff < CNT_W'(CELLS))) begin
         src_ff[lc_ff[ADDR_W-1:0]] <= req_element_value;
      end
      if (s3_valid_ff) begin
         if (bank_ff) begin
            run_a_ff[s3_dst_ff] <= wb_value;
         end else begin
            run_b_ff[s3_dst_ff] <= wb_value;
         end
      end
      // hold the read words while the output is stalled
      if (rd_en) begin
         src_rd_ff   <= src_ff[src_addr[ADDR_W-1:0]];
         run_a_rd_ff <= run_a_ff[run_addr];
         run_b_rd_ff <= run_b_ff[run_addr];
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = ident_ff ? (rsp_diag_ff ? smp_pkg::Q_ONE : W'(0))
                                      : (bank_ff ? run_b_rd_ff : run_a_rd_ff);
   assign rsp_last_element = rsp_last_ff;
   assign rsp_saturated    = clip_ff;

endmodule

// File: rtl/smp_checker.sv
// ----------------------------------------------------------------------------
// smp_checker: port-level checks for the square matrix power block
// Watches the handshakes and the framing of result words.
// ----------------------------------------------------------------------------
module smp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [smp_pkg::WORD_W-1:0]    req_element_value,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [smp_pkg::WORD_W-1:0]    rsp_result_value,
   input logic                          rsp_last_element,
   input logic                          rsp_saturated,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic [smp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [smp_pkg::WORD_W-1:0]    csr_pwdata,
   input logic [smp_pkg::WORD_W-1:0]    csr_prdata,
   input logic                          csr_pready
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_last_element) && $stable(rsp_saturated))
      else $error("result word changed under stall");

   // no input word is taken while a matrix is being sent
   a_no_load_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while sending");

   // the matrix ends after the last mark
   a_end_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_element |=> !rsp_valid)
      else $error("word after last element");

   // words of one matrix follow back to back with one clip flag
   a_frame_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_element |=>
         rsp_valid && (rsp_saturated == $past(rsp_saturated)))
      else $error("matrix broken or clip flag changed");

endmodule

bind square_matrix_power_top smp_checker u_smp_checker (.*);
